FILE: rtl/dqo_pkg.sv
// ---------------------------------------------------------------------------
// dqo_pkg
// Shared types and constants for the decaying quadrature oscillator.
// ---------------------------------------------------------------------------
package dqo_pkg;

  localparam int TIME_W  = 25;
  localparam int PHASE_W = 24;
  localparam int AMP_W   = 16;
  localparam int RATE_W  = 16;
  localparam int LEN_W   = 24;
  localparam int DT_W    = 16;
  localparam int OFS_W   = 17;
  localparam int SIN_W   = 16;
  localparam int AS_W    = AMP_W + SIN_W;     // amplitude * sine
  localparam int PROD_W  = AS_W + TIME_W;     // times remaining time
  localparam int CNT_W   = 5;                 // 32 quotient bits
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd3840;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;    // unused kind, ignored

  localparam logic [1:0] REG_LENGTH = 2'd0;
  localparam logic [1:0] REG_DELAY  = 2'd1;
  localparam logic [1:0] REG_AMP    = 2'd2;
  localparam logic [1:0] REG_RATE   = 2'd3;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_PROD = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_mul;
    logic load_prod;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_calc;
  } sts_t;

endpackage

FILE: rtl/dqo_ctrl.sv
// ---------------------------------------------------------------------------
// dqo_ctrl
// Sequencer: accept, multiply stages, 32-step divide, result hold.
// ---------------------------------------------------------------------------
module dqo_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  dqo_pkg::sts_t  sts,
  output dqo_pkg::cmd_t  cmd
);
  import dqo_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.need_calc ? S_MUL : S_OUT;
        end
      end
      S_MUL: begin
        cmd.load_mul = 1'b1;
        state_nxt    = S_PROD;
      end
      S_PROD: begin
        cmd.load_prod = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == '1) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.load_out = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '1) |=> (state_r == S_FIN))
    else $error("divide did not finish after 32 steps");

  a_no_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && !sts.need_calc) |=> out_valid)
    else $error("plain transaction did not go straight to output");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output open together");

endmodule

FILE: rtl/dqo_datapath.sv
// ---------------------------------------------------------------------------
// dqo_datapath
// Shake state, config registers, sine table, multipliers, divider lanes.
// ---------------------------------------------------------------------------
module dqo_datapath #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_addr,
  input  logic [23:0]                cfg_wdata,
  input  logic [1:0]                 req_type,
  input  logic [dqo_pkg::DT_W-1:0]   delta_time,
  input  dqo_pkg::cmd_t              cmd,
  output dqo_pkg::sts_t              sts,
  output logic [dqo_pkg::OFS_W-1:0]  shift_x,
  output logic [dqo_pkg::OFS_W-1:0]  shift_y,
  output logic                       active
);
  import dqo_pkg::*;

  localparam int D  = SINE_TABLE_DEPTH;
  localparam int KW = $clog2(D);
  localparam int IW = KW + 2;
  localparam longint Q30 = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // quarter-wave sine table, Q1.15, built at elaboration
  logic [SIN_W-1:0] sine_tab [0:D];
  for (genvar g = 0; g < D; g++) begin : g_tab
    localparam longint X  = (HALF_PI_Q30 * g) / D;
    localparam longint T1 = -((((X  * X) / Q30) * X) / Q30) / 6;
    localparam longint T2 = -((((T1 * X) / Q30) * X) / Q30) / 20;
    localparam longint T3 = -((((T2 * X) / Q30) * X) / Q30) / 42;
    localparam longint T4 = -((((T3 * X) / Q30) * X) / Q30) / 72;
    localparam longint T5 = -((((T4 * X) / Q30) * X) / Q30) / 110;
    localparam longint T6 = -((((T5 * X) / Q30) * X) / Q30) / 156;
    localparam longint T7 = -((((T6 * X) / Q30) * X) / Q30) / 210;
    localparam longint SR = X + T1 + T2 + T3 + T4 + T5 + T6 + T7;
    localparam longint SC = (SR < 0) ? 64'sd0 : SR;
    localparam longint V  = (SC * 32768 + Q30 / 2) / Q30;
    localparam longint VC = (V > 32768) ? 64'sd32768 : V;
    assign sine_tab[g] = SIN_W'(VC);
  end
  assign sine_tab[D] = SIN_W'(32768);

  // configuration
  logic [LEN_W-1:0]  len_r, delay_cfg_r;
  logic [AMP_W-1:0]  amp_cfg_r;
  logic [RATE_W-1:0] rate_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      delay_cfg_r <= '0;
      amp_cfg_r   <= '0;
      rate_cfg_r  <= RATE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LENGTH: len_r       <= cfg_wdata;
        REG_DELAY:  delay_cfg_r <= cfg_wdata;
        REG_AMP:    amp_cfg_r   <= cfg_wdata[AMP_W-1:0];
        REG_RATE:   rate_cfg_r  <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // shake state
  logic [TIME_W-1:0]  rem_r, rem_nxt, tot_r, tot_nxt, el_r, el_nxt;
  logic [PHASE_W-1:0] ph_r, ph_nxt;
  logic [AMP_W-1:0]   amp_r, amp_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic [LEN_W-1:0]   hdel_r, hdel_nxt;
  logic [TIME_W:0]    el_sum;
  logic [TIME_W-1:0]  dt_ext;
  logic [DT_W+RATE_W-1:0] dphase;
  logic               tick_live;

  assign dt_ext = TIME_W'(delta_time);
  assign el_sum = {1'b0, el_r} + {1'b0, dt_ext};
  assign dphase = delta_time * rate_r;
  assign tick_live = (req_type == REQ_TICK) && (rem_r != '0);

  always_comb begin
    rem_nxt  = rem_r;
    tot_nxt  = tot_r;
    el_nxt   = el_r;
    ph_nxt   = ph_r;
    amp_nxt  = amp_r;
    rate_nxt = rate_r;
    hdel_nxt = hdel_r;
    case (req_type)
      REQ_START: begin
        tot_nxt  = TIME_W'(len_r) + TIME_W'(delay_cfg_r);
        rem_nxt  = tot_nxt;
        hdel_nxt = delay_cfg_r;
        amp_nxt  = amp_cfg_r;
        rate_nxt = rate_cfg_r;
        el_nxt   = '0;
        ph_nxt   = '0;
      end
      REQ_STOP: begin
        rem_nxt  = '0;
        hdel_nxt = '0;
      end
      REQ_TICK: begin
        if (tick_live) begin
          rem_nxt = (rem_r > dt_ext) ? rem_r - dt_ext : '0;
          el_nxt  = el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
          ph_nxt  = ph_r + dphase[PHASE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign sts.need_calc = tick_live && (rem_nxt != '0) && (el_nxt >= TIME_W'(hdel_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      tot_r  <= '0;
      el_r   <= '0;
      ph_r   <= '0;
      amp_r  <= '0;
      rate_r <= RATE_RESET;
      hdel_r <= '0;
    end else if (cmd.accept) begin
      rem_r  <= rem_nxt;
      tot_r  <= tot_nxt;
      el_r   <= el_nxt;
      ph_r   <= ph_nxt;
      amp_r  <= amp_nxt;
      rate_r <= rate_nxt;
      hdel_r <= hdel_nxt;
    end
  end

  // table lookup: sine and cosine (a quarter turn ahead)
  logic [IW-1:0]  idx;
  logic [1:0]     quad_s, quad_c;
  logic [KW-1:0]  k;
  logic [KW:0]    addr_s, addr_c;

  assign idx    = ph_r[PHASE_W-1 -: IW];
  assign quad_s = idx[IW-1 -: 2];
  assign quad_c = quad_s + 2'd1;
  assign k      = idx[KW-1:0];
  assign addr_s = quad_s[0] ? ((KW+1)'(D) - {1'b0, k}) : {1'b0, k};
  assign addr_c = quad_c[0] ? ((KW+1)'(D) - {1'b0, k}) : {1'b0, k};

  // two lanes: 0 = x (sine), 1 = y (cosine)
  logic [AS_W-1:0]   as_r  [2];
  logic              neg_r [2];
  logic [TIME_W:0]   r_r   [2];
  logic [31:0]       q_r   [2];
  logic [PROD_W-1:0] prod  [2];
  logic [TIME_W:0]   trial [2];
  logic [TIME_W+1:0] diff  [2];
  logic [OFS_W-1:0]  mag   [2];
  logic [OFS_W-1:0]  ofs   [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod[l]  = PROD_W'(as_r[l]) * PROD_W'(rem_r);
      trial[l] = {r_r[l][TIME_W-1:0], q_r[l][31]};
      diff[l]  = {1'b0, trial[l]} - {2'b00, tot_r};
      mag[l]   = q_r[l][31:15];
      ofs[l]   = neg_r[l] ? (OFS_W'(0) - mag[l]) : mag[l];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mul) begin
      as_r[0]  <= AS_W'(amp_r) * AS_W'(sine_tab[addr_s]);
      as_r[1]  <= AS_W'(amp_r) * AS_W'(sine_tab[addr_c]);
      neg_r[0] <= quad_s[1];
      neg_r[1] <= quad_c[1];
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd.load_prod) begin
        // upper part is below the total, so 25 bits carry it
        r_r[l] <= {1'b0, prod[l][PROD_W-1:32]};
        q_r[l] <= prod[l][31:0];
      end else if (cmd.div_step) begin
        r_r[l] <= diff[l][TIME_W+1] ? trial[l] : diff[l][TIME_W:0];
        q_r[l] <= {q_r[l][30:0], ~diff[l][TIME_W+1]};
      end
    end
  end

  // result register
  logic [OFS_W-1:0] ox_r, oy_r;
  logic             act_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ox_r  <= '0;
      oy_r  <= '0;
      act_r <= (rem_nxt != '0);
    end else if (cmd.load_out) begin
      ox_r <= ofs[0];
      oy_r <= ofs[1];
    end
  end

  assign shift_x = ox_r;
  assign shift_y = oy_r;
  assign active  = act_r;

endmodule

FILE: rtl/decaying_quadrature_oscillator.sv
// ---------------------------------------------------------------------------
// decaying_quadrature_oscillator
// Linearly decaying sine/cosine offset generator (camera shake).
// ---------------------------------------------------------------------------
// Input channel (in_*): one transaction per request. in_tuser carries the
// request kind (tick, start, stop), in_tdata the tick time step.
// Output channel (out_*): exactly one transaction per input transaction,
// carrying shift_x, shift_y (signed Q9.8) and the active flag.
// Config port (cfg_*): length, delay, amplitude, rate; written while idle.
// Start latches the config, stop ends the shake, a tick advances time and
// phase and, past the delay, yields amplitude * sin/cos * remaining/total.
// Start, stop, idle ticks and ticks inside the delay give their result in
// the cycle after acceptance. A shaking tick passes two multiply stages, a
// 32-step radix-2 restoring divide (both lanes in parallel) and an output
// load. One transaction is in flight at a time; the next is accepted the
// cycle after the result is taken.
// Reset (rst_n, synchronous): shake inactive, rate 15 Hz, other config and shake regs zero; result regs not reset.
// A stalled receiver simply holds the result; input stays not ready.
// ---------------------------------------------------------------------------
module decaying_quadrature_oscillator #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] delta_time
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [16:0] shift_x, [33:17] shift_y, [34] active
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);
  import dqo_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [OFS_W-1:0]  shift_x, shift_y;
  logic              active;

  dqo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dqo_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .req_type   (in_tuser),
    .delta_time (in_tdata[DT_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .shift_x    (shift_x),
    .shift_y    (shift_y),
    .active     (active)
  );

  assign out_tdata = {5'd0, active, shift_y, shift_x};

endmodule
